@@ src/msd_pkg.sv @@
package msd_pkg;

    localparam int DIGIT_COUNT_DEF = 6;
    localparam int ENABLE_W        = 6;
    localparam int SEG_W           = 7;
    localparam int CHAR_W          = 8;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CHAR_TWO   = 8'h32;
    localparam logic [CHAR_W-1:0] CHAR_THREE = 8'h33;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;

    localparam logic [CHAR_W-1:0] STATUS_SW_LOW  = CHAR_ONE;
    localparam logic [CHAR_W-1:0] STATUS_SW_HIGH = CHAR_TWO;

    localparam logic [SEG_W-1:0] SEG_DASH = 7'h3F;

    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        7'h40, 7'h73, 7'h24, 7'h21, 7'h13, 7'h09, 7'h08, 7'h63, 7'h00, 7'h01
    };

    typedef struct packed {
        logic             hit;
        logic [SEG_W-1:0] pattern;
    } seg_dec_t;

endpackage

@@ src/msd_seg_decode.sv @@
module msd_seg_decode (
    input  logic [msd_pkg::CHAR_W-1:0] char_in,
    input  logic                       is_last,
    input  logic                       patch_en,
    output msd_pkg::seg_dec_t          dec
);
    import msd_pkg::*;

    logic [CHAR_W-1:0] char_mapped;

    // last-digit remap, display only
    always_comb begin
        char_mapped = char_in;
        if (patch_en && is_last) begin
            if (char_in == CHAR_ZERO) begin
                char_mapped = CHAR_ONE;
            end else if (char_in == CHAR_TWO) begin
                char_mapped = CHAR_THREE;
            end
        end
    end

    always_comb begin
        dec.hit     = 1'b0;
        dec.pattern = SEG_DASH;
        if (char_mapped >= CHAR_ZERO && char_mapped <= CHAR_NINE) begin
            dec.hit     = 1'b1;
            dec.pattern = DIGIT_SEGS[char_mapped[3:0]];
        end else if (char_mapped == CHAR_DASH) begin
            dec.hit     = 1'b1;
            dec.pattern = SEG_DASH;
        end
    end

endmodule

@@ src/multiplexed_seven_segment_driver.sv @@
// An accepted beat is registered in the input stage, then processed; its result
// beat is registered in the result stage, and result backpressure can stall it.
// Throughput: one beat per cycle, limited only by result backpressure.
// Reset (aresetn low, synchronous): store returns to alternating '-','1',
// write pointer 0, scan at last digit, segments all lit, digits off, patch on.
module multiplexed_seven_segment_driver #(
    parameter int DIGIT_COUNT = msd_pkg::DIGIT_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [msd_pkg::CHAR_W-1:0]   s_data_byte,
    input  logic                         s_first_byte,
    input  logic                         s_switch_level,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [msd_pkg::CHAR_W-1:0]   m_read_data,
    output logic [msd_pkg::ENABLE_W-1:0] m_digit_enable,
    output logic [msd_pkg::SEG_W-1:0]    m_segment_bits
);
    import msd_pkg::*;

    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int PTR_W = $clog2(DIGIT_COUNT + 1);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(DIGIT_COUNT - 1);
    localparam logic [PTR_W-1:0] PTR_LIMIT = PTR_W'(DIGIT_COUNT);

    // input stage
    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [CHAR_W-1:0] in_data_reg;
    logic              in_first_reg;
    logic              in_sw_reg;

    // display state
    logic [CHAR_W-1:0] chars_reg [DIGIT_COUNT];
    logic [CHAR_W-1:0] chars_next [DIGIT_COUNT];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [POS_W-1:0]  scan_pos_reg, scan_pos_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [ENABLE_W-1:0] en_reg, en_next;
    logic              patch_reg;

    // result stage
    logic              out_valid_reg;
    logic [CHAR_W-1:0] rd_reg, rd_next;

    logic              advance;
    logic              s_accept;
    logic [PTR_W-1:0]  ptr_base;
    logic [POS_W-1:0]  scan_step;
    seg_dec_t          dec;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign scan_step = (scan_pos_reg == LAST_POS) ? '0 : scan_pos_reg + 1'b1;
    assign ptr_base  = in_first_reg ? '0 : wr_ptr_reg;

    msd_seg_decode u_seg_decode (
        .char_in  (chars_reg[scan_step]),
        .is_last  (scan_step == LAST_POS),
        .patch_en (patch_reg),
        .dec      (dec)
    );

    always_comb begin
        chars_next    = chars_reg;
        wr_ptr_next   = wr_ptr_reg;
        scan_pos_next = scan_pos_reg;
        seg_next      = seg_reg;
        en_next       = en_reg;
        rd_next       = '0;
        case (in_cmd_reg)
            CMD_WRITE: begin
                if (ptr_base < PTR_LIMIT) begin
                    chars_next[ptr_base[POS_W-1:0]] = in_data_reg;
                    wr_ptr_next = ptr_base + 1'b1;
                end else begin
                    wr_ptr_next = ptr_base;
                end
            end
            CMD_READ: begin
                rd_next = in_sw_reg ? STATUS_SW_HIGH : STATUS_SW_LOW;
            end
            CMD_TICK: begin
                scan_pos_next = scan_step;
                for (int i = 0; i < ENABLE_W; i++) begin
                    en_next[i] = (i < DIGIT_COUNT) && (scan_step == POS_W'(i));
                end
                if (dec.hit) begin
                    seg_next = dec.pattern;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_ptr_reg    <= '0;
            scan_pos_reg  <= LAST_POS;
            seg_reg       <= '0;
            en_reg        <= '0;
            patch_reg     <= 1'b1;
            for (int k = 0; k < DIGIT_COUNT; k++) begin
                chars_reg[k] <= k[0] ? CHAR_ONE : CHAR_DASH;
            end
        end else begin
            if (cfg_we) begin
                patch_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                chars_reg     <= chars_next;
                wr_ptr_reg    <= wr_ptr_next;
                scan_pos_reg  <= scan_pos_next;
                seg_reg       <= seg_next;
                en_reg        <= en_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg   <= cmd_t'(s_cmd);
            in_data_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
            in_sw_reg    <= s_switch_level;
        end
        if (advance) begin
            rd_reg <= rd_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = rd_reg;
    assign m_digit_enable = en_reg;
    assign m_segment_bits = seg_reg;

    a_enable_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(en_reg))
        else $error("digit enable not one-hot");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg <= PTR_LIMIT)
        else $error("write pointer past store");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_pos_reg <= LAST_POS)
        else $error("scan position past last digit");

    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed beat produced no result");

    a_tick_enables_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == CMD_TICK) |=>
            (scan_pos_reg >= POS_W'(ENABLE_W) && DIGIT_COUNT > ENABLE_W) ||
            en_reg == ENABLE_W'(1) << scan_pos_reg)
        else $error("enable does not follow scan position");

endmodule
